// ----- src/pulse_rate_meter_and_pacer_macros.svh -----
// assertion macros used by the prmp_ctrl module of the pulse rate meter and pacer
// expects clk and rst_n to be visible where a macro is used
`ifndef PULSE_RATE_METER_AND_PACER_MACROS_SVH
`define PULSE_RATE_METER_AND_PACER_MACROS_SVH

// same-cycle implication
`define PRMP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prmp check failed");

// next-cycle implication
`define PRMP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prmp check failed");

`endif

// ----- src/prmp_pkg.sv -----
// shared types and constants of the pulse rate meter and pacer
// no dependencies
package prmp_pkg;

    // parameter defaults
    localparam int SAMPLE_PHASE_LAST_DEF = 4;
    localparam int FRAME_LAST_INDEX_DEF  = 127;
    localparam int WINDOW_LAST_FRAME_DEF = 2;
    localparam int ADC_BITS_DEF          = 10;

    // field and state widths
    localparam int LEVEL_W    = 6;
    localparam int MARGIN_W   = 6;
    localparam int HIGH_W     = 8;
    localparam int INTERVAL_W = 11;
    localparam int BPM_W      = 12;
    localparam int PHASE_W    = 3;
    localparam int COUNT_W    = 16;
    localparam int SIDX_W     = 7;
    localparam int FIDX_W     = 2;
    localparam int BEATS_W    = 8;
    localparam int THRESH_W   = 8;

    // scaling and rate constants
    localparam int                  LEVEL_SCALE  = 40;
    localparam logic [9:0]          RATE_MULT    = 10'd625;
    localparam int                  RATE_SHIFT   = 6;
    localparam logic [INTERVAL_W-1:0] DIVIDEND   = 11'd1536;
    localparam int                  DIV_ITER     = INTERVAL_W;
    localparam int                  DIV_CNT_W    = 4;

    // reset values
    localparam logic [MARGIN_W-1:0]   PEAK_MARGIN_RST  = 6'd2;
    localparam logic [HIGH_W-1:0]     PACE_HIGH_RST    = 8'd25;
    localparam logic [INTERVAL_W-1:0] INTERVAL_MIN_RST = 11'd20;
    localparam logic [INTERVAL_W-1:0] INTERVAL_MAX_RST = 11'd300;
    localparam logic [BPM_W-1:0]      RATE_RST         = 12'd60;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RST     = 11'd250;

    // apb register map
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_PEAK_MARGIN  = 2'd0,
        REG_PACE_HIGH    = 2'd1,
        REG_INTERVAL_MIN = 2'd2,
        REG_INTERVAL_MAX = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [MARGIN_W-1:0]   peak_margin;
        logic [HIGH_W-1:0]     pace_high_ticks;
        logic [INTERVAL_W-1:0] interval_min;
        logic [INTERVAL_W-1:0] interval_max;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic tick;
        logic div_step;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_needed;
        logic div_last;
    } dp_sts_t;

endpackage

// ----- src/pulse_rate_meter_and_pacer.sv -----
// pulse rate meter and pacer, top level
// depends on prmp_pkg, prmp_regs, prmp_ctrl and prmp_dpath
//
// usage:
//   input channel in_valid/in_ready carries one timer tick with adc_sample per beat
//   output channel out_valid/out_ready returns one result beat per tick: pacing
//   level, sampling, beat and rate-update flags, scaled level and current beats per minute
//   apb port holds peak_margin, pace_high_ticks, interval_min, interval_max
//   at byte addresses 0, 4, 8, 12; write them only while no tick is in flight
//   latency: the result beat is valid the cycle after the tick is accepted
//   throughput: one tick per cycle; a tick that closes a rate window with a
//   nonzero beat count starts the serial interval divider, which holds in_ready
//   low while it produces the quotient, one quotient bit per cycle
//   reset clears all counters, sets the rate to 60 and the pacing interval to 250
//   a stalled receiver holds the result beat; in_ready stays high only while the
//   output register is empty or being drained in the same cycle
module pulse_rate_meter_and_pacer #(
    parameter int SAMPLE_PHASE_LAST = prmp_pkg::SAMPLE_PHASE_LAST_DEF,
    parameter int FRAME_LAST_INDEX  = prmp_pkg::FRAME_LAST_INDEX_DEF,
    parameter int WINDOW_LAST_FRAME = prmp_pkg::WINDOW_LAST_FRAME_DEF,
    parameter int ADC_BITS          = prmp_pkg::ADC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [prmp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [prmp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [prmp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ADC_BITS-1:0]               adc_sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              pace_level,
    output logic                              sample_taken,
    output logic [prmp_pkg::LEVEL_W-1:0]      scaled_level,
    output logic                              beat_seen,
    output logic                              rate_updated,
    output logic [prmp_pkg::BPM_W-1:0]        beats_per_minute
);

    prmp_pkg::cfg_t    cfg;
    prmp_pkg::dp_cmd_t cmd;
    prmp_pkg::dp_sts_t sts;

    prmp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    prmp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    prmp_dpath #(
        .SAMPLE_PHASE_LAST (SAMPLE_PHASE_LAST),
        .FRAME_LAST_INDEX  (FRAME_LAST_INDEX),
        .WINDOW_LAST_FRAME (WINDOW_LAST_FRAME),
        .ADC_BITS          (ADC_BITS)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .cmd              (cmd),
        .sts              (sts),
        .adc_sample       (adc_sample),
        .pace_level       (pace_level),
        .sample_taken     (sample_taken),
        .scaled_level     (scaled_level),
        .beat_seen        (beat_seen),
        .rate_updated     (rate_updated),
        .beats_per_minute (beats_per_minute)
    );

endmodule

// ----- src/prmp_regs.sv -----
// apb configuration registers of the pulse rate meter and pacer
// depends on prmp_pkg
module prmp_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [prmp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [prmp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [prmp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output prmp_pkg::cfg_t                    cfg
);

    prmp_pkg::cfg_t     cfg_reg;
    prmp_pkg::cfg_t     cfg_next;
    prmp_pkg::reg_idx_t idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign idx    = prmp_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                prmp_pkg::REG_PEAK_MARGIN:
                    cfg_next.peak_margin = pwdata[prmp_pkg::MARGIN_W-1:0];
                prmp_pkg::REG_PACE_HIGH:
                    cfg_next.pace_high_ticks = pwdata[prmp_pkg::HIGH_W-1:0];
                prmp_pkg::REG_INTERVAL_MIN:
                    cfg_next.interval_min = pwdata[prmp_pkg::INTERVAL_W-1:0];
                prmp_pkg::REG_INTERVAL_MAX:
                    cfg_next.interval_max = pwdata[prmp_pkg::INTERVAL_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            prmp_pkg::REG_PEAK_MARGIN:
                prdata = prmp_pkg::APB_DATA_W'(cfg_reg.peak_margin);
            prmp_pkg::REG_PACE_HIGH:
                prdata = prmp_pkg::APB_DATA_W'(cfg_reg.pace_high_ticks);
            prmp_pkg::REG_INTERVAL_MIN:
                prdata = prmp_pkg::APB_DATA_W'(cfg_reg.interval_min);
            prmp_pkg::REG_INTERVAL_MAX:
                prdata = prmp_pkg::APB_DATA_W'(cfg_reg.interval_max);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.peak_margin     <= prmp_pkg::PEAK_MARGIN_RST;
            cfg_reg.pace_high_ticks <= prmp_pkg::PACE_HIGH_RST;
            cfg_reg.interval_min    <= prmp_pkg::INTERVAL_MIN_RST;
            cfg_reg.interval_max    <= prmp_pkg::INTERVAL_MAX_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- src/prmp_dpath.sv -----
// datapath: pacing counter, sampling, peak and beat tracking, rate and serial divider
// depends on prmp_pkg
module prmp_dpath #(
    parameter int SAMPLE_PHASE_LAST = prmp_pkg::SAMPLE_PHASE_LAST_DEF,
    parameter int FRAME_LAST_INDEX  = prmp_pkg::FRAME_LAST_INDEX_DEF,
    parameter int WINDOW_LAST_FRAME = prmp_pkg::WINDOW_LAST_FRAME_DEF,
    parameter int ADC_BITS          = prmp_pkg::ADC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  prmp_pkg::cfg_t                      cfg,
    input  prmp_pkg::dp_cmd_t                   cmd,
    output prmp_pkg::dp_sts_t                   sts,
    input  logic [ADC_BITS-1:0]                 adc_sample,
    output logic                                pace_level,
    output logic                                sample_taken,
    output logic [prmp_pkg::LEVEL_W-1:0]        scaled_level,
    output logic                                beat_seen,
    output logic                                rate_updated,
    output logic [prmp_pkg::BPM_W-1:0]          beats_per_minute
);

    localparam int PROD_W = ADC_BITS + prmp_pkg::LEVEL_W;
    localparam logic [prmp_pkg::PHASE_W-1:0] PHASE_LAST =
        prmp_pkg::PHASE_W'(SAMPLE_PHASE_LAST);
    localparam logic [prmp_pkg::SIDX_W-1:0] SIDX_LAST =
        prmp_pkg::SIDX_W'(FRAME_LAST_INDEX);
    localparam logic [prmp_pkg::FIDX_W-1:0] FIDX_LAST =
        prmp_pkg::FIDX_W'(WINDOW_LAST_FRAME);

    // tick state
    logic [prmp_pkg::PHASE_W-1:0]    phase_reg, phase_next;
    logic [prmp_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [prmp_pkg::SIDX_W-1:0]     sidx_reg, sidx_next;
    logic [prmp_pkg::FIDX_W-1:0]     fidx_reg, fidx_next;
    logic [prmp_pkg::LEVEL_W-1:0]    peak_reg, peak_next;
    logic                            above_reg, above_next;
    logic [prmp_pkg::BEATS_W-1:0]    beats_reg, beats_next;
    logic [prmp_pkg::BPM_W-1:0]      rate_reg, rate_next;
    logic [prmp_pkg::INTERVAL_W-1:0] interval_reg, interval_next;
    logic                            pin_reg, pin_next;

    // divider state
    logic [prmp_pkg::BEATS_W-1:0]    divisor_reg, divisor_next;
    logic [prmp_pkg::BEATS_W-1:0]    rem_reg, rem_next;
    logic [prmp_pkg::INTERVAL_W-1:0] quo_reg, quo_next;
    logic [prmp_pkg::DIV_CNT_W-1:0]  dcnt_reg, dcnt_next;

    // result register
    logic                            pace_level_reg;
    logic                            sample_taken_reg;
    logic [prmp_pkg::LEVEL_W-1:0]    scaled_level_reg;
    logic                            beat_seen_reg;
    logic                            rate_updated_reg;
    logic [prmp_pkg::BPM_W-1:0]      bpm_reg;

    // combinational terms
    logic                            out_of_bounds;
    logic [prmp_pkg::INTERVAL_W:0]   pulse_end;
    logic                            pulse_start_hit;
    logic                            pulse_end_hit;
    logic                            pace_restart;
    logic                            sample;
    logic [PROD_W-1:0]               scale_prod;
    logic [prmp_pkg::LEVEL_W-1:0]    level;
    logic [prmp_pkg::LEVEL_W-1:0]    peak_upd;
    logic [prmp_pkg::THRESH_W-1:0]   threshold;
    logic                            beat;
    logic [prmp_pkg::BEATS_W-1:0]    beats_inc;
    logic                            frame_end;
    logic                            window_end;
    logic [17:0]                     rate_prod;
    logic [prmp_pkg::BEATS_W:0]      rem_shift;
    logic                            rem_fits;

    // pacing
    assign out_of_bounds = (interval_reg > cfg.interval_max) || (interval_reg < cfg.interval_min);
    assign pulse_end     = {1'b0, interval_reg}
                         + (prmp_pkg::INTERVAL_W + 1)'(cfg.pace_high_ticks);
    assign pulse_start_hit = count_reg >= prmp_pkg::COUNT_W'(interval_reg);
    assign pulse_end_hit   = count_reg >= prmp_pkg::COUNT_W'(pulse_end);
    assign pace_restart    = !out_of_bounds && pulse_start_hit && pulse_end_hit;

    always_comb
    begin
        pin_next = pin_reg;
        if (out_of_bounds)
            pin_next = 1'b1;
        else if (pulse_start_hit)
            pin_next = !pulse_end_hit;
    end

    assign count_next = (pace_restart ? prmp_pkg::COUNT_W'(cfg.pace_high_ticks) : count_reg)
                      + prmp_pkg::COUNT_W'(1);

    // sampling and peak tracking; adc*40 as two shifted adds
    assign sample     = phase_reg >= PHASE_LAST;
    assign scale_prod = (PROD_W'(adc_sample) << 5) + (PROD_W'(adc_sample) << 3);
    assign level      = scale_prod[ADC_BITS +: prmp_pkg::LEVEL_W];
    assign peak_upd   = (level >= peak_reg) ? level : peak_reg;
    assign threshold  = prmp_pkg::THRESH_W'(peak_upd) - prmp_pkg::THRESH_W'(cfg.peak_margin);
    assign beat       = sample && !above_reg && (prmp_pkg::THRESH_W'(level) > threshold);
    assign beats_inc  = beat ? beats_reg + prmp_pkg::BEATS_W'(1) : beats_reg;
    assign frame_end  = sample && (sidx_reg >= SIDX_LAST);
    assign window_end = frame_end && (fidx_reg == FIDX_LAST);
    assign rate_prod  = 18'(beats_inc) * 18'(prmp_pkg::RATE_MULT);

    always_comb
    begin
        above_next = above_reg;
        if (sample)
        begin
            if (beat)
                above_next = 1'b1;
            else if (above_reg && (prmp_pkg::THRESH_W'(level) <= threshold))
                above_next = 1'b0;
        end
    end

    assign phase_next = sample ? prmp_pkg::PHASE_W'(1) : phase_reg + prmp_pkg::PHASE_W'(1);
    assign peak_next  = frame_end ? '0 : (sample ? peak_upd : peak_reg);
    assign beats_next = window_end ? '0 : beats_inc;
    assign rate_next  = window_end ? rate_prod[prmp_pkg::RATE_SHIFT +: prmp_pkg::BPM_W]
                                   : rate_reg;

    always_comb
    begin
        sidx_next = sidx_reg;
        fidx_next = fidx_reg;
        if (sample)
            sidx_next = frame_end ? prmp_pkg::SIDX_W'(1) : sidx_reg + prmp_pkg::SIDX_W'(1);
        if (frame_end)
            fidx_next = (fidx_reg >= FIDX_LAST) ? '0 : fidx_reg + prmp_pkg::FIDX_W'(1);
    end

    // restoring divider, one quotient bit per step
    assign rem_shift = {rem_reg, quo_reg[prmp_pkg::INTERVAL_W-1]};
    assign rem_fits  = rem_shift >= {1'b0, divisor_reg};

    always_comb
    begin
        divisor_next  = divisor_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        dcnt_next     = dcnt_reg;
        interval_next = interval_reg;
        if (cmd.tick && window_end)
        begin
            divisor_next = beats_inc;
            rem_next     = '0;
            quo_next     = prmp_pkg::DIVIDEND;
            if (beats_inc == '0)
                interval_next = '0;
            else
                dcnt_next = prmp_pkg::DIV_CNT_W'(prmp_pkg::DIV_ITER);
        end
        else if (cmd.div_step)
        begin
            rem_next  = rem_fits ? prmp_pkg::BEATS_W'(rem_shift - {1'b0, divisor_reg})
                                 : rem_shift[prmp_pkg::BEATS_W-1:0];
            quo_next  = {quo_reg[prmp_pkg::INTERVAL_W-2:0], rem_fits};
            dcnt_next = dcnt_reg - prmp_pkg::DIV_CNT_W'(1);
            if (sts.div_last)
                interval_next = quo_next;
        end
    end

    assign sts.div_needed = window_end && (beats_inc != '0);
    assign sts.div_last   = dcnt_reg == prmp_pkg::DIV_CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            count_reg    <= '0;
            sidx_reg     <= '0;
            fidx_reg     <= '0;
            peak_reg     <= '0;
            above_reg    <= 1'b0;
            beats_reg    <= '0;
            rate_reg     <= prmp_pkg::RATE_RST;
            pin_reg      <= 1'b0;
            interval_reg <= prmp_pkg::INTERVAL_RST;
            dcnt_reg     <= '0;
        end
        else
        begin
            if (cmd.tick)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                sidx_reg  <= sidx_next;
                fidx_reg  <= fidx_next;
                peak_reg  <= peak_next;
                above_reg <= above_next;
                beats_reg <= beats_next;
                rate_reg  <= rate_next;
                pin_reg   <= pin_next;
            end
            interval_reg <= interval_next;
            dcnt_reg     <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        if (cmd.tick)
        begin
            pace_level_reg   <= pin_next;
            sample_taken_reg <= sample;
            scaled_level_reg <= sample ? level : '0;
            beat_seen_reg    <= beat;
            rate_updated_reg <= window_end;
            bpm_reg          <= rate_next;
        end
    end

    assign pace_level       = pace_level_reg;
    assign sample_taken     = sample_taken_reg;
    assign scaled_level     = scaled_level_reg;
    assign beat_seen        = beat_seen_reg;
    assign rate_updated     = rate_updated_reg;
    assign beats_per_minute = bpm_reg;

endmodule

// ----- src/prmp_ctrl.sv -----
// controller: handshakes, result valid and divider sequencing
// depends on prmp_pkg and pulse_rate_meter_and_pacer_macros.svh
`include "pulse_rate_meter_and_pacer_macros.svh"

module prmp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output prmp_pkg::dp_cmd_t   cmd,
    input  prmp_pkg::dp_sts_t   sts
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DIV  = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign cmd.tick     = accept;
    assign cmd.div_step = state_reg == ST_DIV;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && sts.div_needed)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_last)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // result beat waits in the output register until taken
    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `PRMP_ASSERT_NOW(a_no_accept_while_dividing, state_reg == ST_DIV, !in_ready)
    `PRMP_ASSERT_NEXT(a_accept_gives_result, accept, out_valid_reg)
    `PRMP_ASSERT_NOW(a_div_last_only_dividing, sts.div_last, state_reg == ST_DIV)
    `PRMP_ASSERT_NOW(a_accept_needs_free_output, accept, !out_valid_reg || out_ready)

endmodule
